FILE: hw/rtl/bia_pkg.sv
package bia_pkg;

    // Size of the identifier space and of one map word.
    localparam int ID_COUNT  = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ID_W      = WADDR_W + BIT_W;

    // Widths of the request and result fields.
    localparam int KIND_W     = 2;
    localparam int ID_FIELD_W = 12;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bitpos_t;

    // One result as it travels from the controller to the output buffer.
    typedef struct packed {
        logic [ID_FIELD_W-1:0] granted_id;
        logic                  exhausted;
        logic                  rejected;
    } result_t;

    // Bits of the last word that lie beyond the identifier space; they read as used.
    function automatic word_t last_word_mask();
        word_t m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if ((MAP_WORDS - 1) * WORD_BITS + i >= ID_COUNT)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam word_t LAST_MASK = last_word_mask();

    // Lowest clear bit of a word; only meaningful when the word is not all ones.
    function automatic bitpos_t first_zero(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: hw/rtl/bitmap_id_allocator.sv
// Channel | Signals                                   | Direction
// request | in_valid, in_stall, kind, id_to_free      | into the block
// result  | out_valid, out_stall, granted_id,         | out of the block
//         |   exhausted, rejected                     |
//
// An allocate reads the map one word per cycle from word 0 and stops at the first
// word with a free bit. A valid free reads its word, then writes it back; rejected
// frees, clears and unused kinds finish in the cycle they are accepted.
// Reset and clear drop the per-word valid bits at once; a word that is not valid
// reads as the reset map, so no clearing pass is needed.
// A result waits in a two-entry buffer while out_stall is high; in_stall rises
// while a request is in progress or the buffer's spare entry is taken.
module bitmap_id_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bia_pkg::KIND_W-1:0]     kind,
    input  logic [bia_pkg::ID_FIELD_W-1:0] id_to_free,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bia_pkg::ID_FIELD_W-1:0] granted_id,
    output logic                           exhausted,
    output logic                           rejected
);
    import bia_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR
    } state_t;

    state_t               state_reg, state_next;
    waddr_t               addr_reg, addr_next;
    bitpos_t              bit_reg, bit_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;

    logic    accept;
    logic    buf_full;
    logic    res_load;
    result_t res;
    logic    free_bad;
    waddr_t  free_word;
    bitpos_t free_bit;

    logic    ram_we;
    word_t   ram_wdata;
    logic    ram_re;
    waddr_t  ram_raddr;
    word_t   ram_rdata;

    word_t   cur_word;
    word_t   masked_word;
    logic    word_has_free;
    bitpos_t free_pos;
    logic    last_word;
    logic [ID_W-1:0] found_id;

    assign in_stall = (state_reg != ST_IDLE) || buf_full;
    assign accept   = in_valid && !in_stall;

    // Decode of a free request.
    assign free_bad  = (id_to_free == '0) || (32'(id_to_free) >= ID_COUNT);
    assign free_word = WADDR_W'(id_to_free >> BIT_W);
    assign free_bit  = BIT_W'(id_to_free);

    // Current map word: memory data if written since the last clear, else the reset map.
    always_comb
    begin
        if (valid_reg[addr_reg])
        begin
            cur_word = ram_rdata;
        end
        else if (addr_reg == '0)
        begin
            cur_word = WORD_BITS'(1);
        end
        else
        begin
            cur_word = '0;
        end
    end

    // Search of the current word for a free identifier.
    assign last_word     = (addr_reg == WADDR_W'(MAP_WORDS - 1));
    assign masked_word   = last_word ? (cur_word | LAST_MASK) : cur_word;
    assign word_has_free = !(&masked_word);
    assign free_pos      = first_zero(masked_word);
    assign found_id      = {addr_reg, free_pos};

    // Read address: word 0 or the freed word at acceptance, the next word while scanning.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (state_reg == ST_IDLE)
        begin
            ram_re    = accept;
            ram_raddr = (kind == KIND_FREE) ? free_word : '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            ram_re    = 1'b1;
            ram_raddr = addr_reg + WADDR_W'(1);
        end
    end

    // Sequencer: next state, write back and result.
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        bit_next   = bit_reg;
        valid_next = valid_reg;
        ram_we     = 1'b0;
        ram_wdata  = cur_word;
        res_load   = 1'b0;
        res        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_ALLOC:
                        begin
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                        KIND_FREE:
                        begin
                            if (free_bad)
                            begin
                                res.rejected = 1'b1;
                                res_load     = 1'b1;
                            end
                            else
                            begin
                                addr_next  = free_word;
                                bit_next   = free_bit;
                                state_next = ST_FREE_WR;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            valid_next = '0;
                            res_load   = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (word_has_free)
                begin
                    ram_we               = 1'b1;
                    ram_wdata            = cur_word | (WORD_BITS'(1) << free_pos);
                    valid_next[addr_reg] = 1'b1;
                    res.granted_id       = ID_FIELD_W'(found_id);
                    res_load             = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (last_word)
                begin
                    res.exhausted = 1'b1;
                    res_load      = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + WADDR_W'(1);
                end
            end
            ST_FREE_WR:
            begin
                ram_we               = 1'b1;
                ram_wdata            = cur_word & ~(WORD_BITS'(1) << bit_reg);
                valid_next[addr_reg] = 1'b1;
                res_load             = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            addr_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
            bit_reg   <= bit_next;
        end
    end

    // Used map, one word per entry.
    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result buffer toward the output channel.
    bia_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .res        (res),
        .full       (buf_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted_id (granted_id),
        .exhausted  (exhausted),
        .rejected   (rejected)
    );

endmodule

FILE: hw/rtl/bia_ram.sv
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bia_out_buf.sv
module bia_out_buf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  bia_pkg::result_t                  res,
    output logic                              full,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bia_pkg::ID_FIELD_W-1:0]    granted_id,
    output logic                              exhausted,
    output logic                              rejected
);
    import bia_pkg::*;

    logic    pend_valid_reg;
    result_t pend_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;

    // The output slot can take a new result when it is empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Control: a pending slot catches a result while the output slot is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= load;
            end
            else
            begin
                out_valid_reg <= load;
            end
        end
        else if (load)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    // Payload moves along with the control above.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_reg  <= pend_reg;
                pend_reg <= res;
            end
            else if (load)
            begin
                out_reg <= res;
            end
        end
        else if (load)
        begin
            pend_reg <= res;
        end
    end

    assign full       = pend_valid_reg;
    assign out_valid  = out_valid_reg;
    assign granted_id = out_reg.granted_id;
    assign exhausted  = out_reg.exhausted;
    assign rejected   = out_reg.rejected;

endmodule

FILE: hw/rtl/bia_checker.sv
module bia_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [bia_pkg::KIND_W-1:0]     kind,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [bia_pkg::ID_FIELD_W-1:0] granted_id,
    input logic                           exhausted,
    input logic                           rejected
);
    import bia_pkg::*;

    // A held result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(granted_id)
            && $stable(exhausted) && $stable(rejected))
        else $error("held result changed");

    // An exhausted allocate grants nothing and is not a rejected free.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> granted_id == '0 && !rejected)
        else $error("exhausted result carries a grant or reject");

    // A rejected free grants nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> granted_id == '0 && !exhausted)
        else $error("rejected result carries a grant or exhausted");

    // An allocate always needs at least one map read, so the request side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_ALLOC |=> in_stall)
        else $error("allocate did not stall the request side");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

FILE: dv/bitmap_id_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_id_allocator_test;
    import bia_pkg::*;

    // The request kind that the block takes but ignores.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int FILL_REQUESTS   = 700;
    localparam int RANDOM_REQUESTS = 920;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_AFTER      = 1000;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 100;

    // Keeps its own copy of the used map and the results it predicts for
    // every accepted request, oldest first.
    class id_map_scoreboard;
        logic [ID_COUNT-1:0] used_ids;
        int                  alloc_peak;
        result_t             expected_q[$];
        int                  mismatches;

        function new();
            mismatches = 0;
            clear_map();
        endfunction

        // Only identifier 0 stays reserved after reset or a clear.
        function void clear_map();
            used_ids    = '0;
            used_ids[0] = 1'b1;
            alloc_peak  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the result of an accepted request and updates the map.
        function void note_request(input logic [KIND_W-1:0] k,
                                   input logic [ID_FIELD_W-1:0] id);
            result_t res;
            int      i;
            res = '0;
            case (k)
                KIND_ALLOC:
                begin
                    i = 1;
                    while (i < ID_COUNT && used_ids[i])
                    begin
                        i++;
                    end
                    if (i < ID_COUNT)
                    begin
                        used_ids[i]    = 1'b1;
                        res.granted_id = ID_FIELD_W'(i);
                        if (i > alloc_peak)
                        begin
                            alloc_peak = i;
                        end
                    end
                    else
                    begin
                        res.exhausted = 1'b1;
                    end
                end
                KIND_FREE:
                begin
                    if (id == '0 || int'(id) >= ID_COUNT)
                    begin
                        res.rejected = 1'b1;
                    end
                    else
                    begin
                        used_ids[id] = 1'b0;
                    end
                end
                KIND_CLEAR:
                begin
                    clear_map();
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(res);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(input logic [ID_FIELD_W-1:0] g, input logic e,
                                   input logic r);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result with no request pending: %s%0d %s%b %s%b",
                             $time, "granted_id=", g, "exhausted=", e,
                             "rejected=", r);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (g !== want.granted_id || e !== want.exhausted || r !== want.rejected)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: expected granted_id=%0d exhausted=%b rejected=%b,",
                                 $time, want.granted_id, want.exhausted, want.rejected);
                        $display("    got granted_id=%0d exhausted=%b rejected=%b",
                                 g, e, r);
                    end
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind       = KIND_ALLOC;
    logic [ID_FIELD_W-1:0] id_to_free = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [ID_FIELD_W-1:0] granted_id;
    logic                  exhausted;
    logic                  rejected;

    id_map_scoreboard sb = new();

    int burst_left   = 0;
    int results_seen = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    bitmap_id_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .id_to_free (id_to_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted_id (granted_id),
        .exhausted  (exhausted),
        .rejected   (rejected)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request and waits until the block takes it. Requests go out in
    // bursts; a gap of idle cycles may come before a new burst.
    task automatic send_req(input logic [KIND_W-1:0] k, input logic [ID_FIELD_W-1:0] id);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid   <= 1'b1;
        kind       <= k;
        id_to_free <= id;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(k, id);
    endtask

    // Stops offering requests until every predicted result has come back.
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: check each accepted result, then choose the next stall.
    // The stall pattern switches among a few modes; once, it holds off for a
    // long stretch so that the block backs up into its request side.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(granted_id, exhausted, rejected);
            results_seen++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= (mode_left % 4 == 0);
                default: out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    // Ends the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bitmap_id_allocator: mismatch");
            $finish;
        end
    end

    // Request sequence: directed cases, a fill of the low map words, then random
    // traffic.
    initial
    begin
        int                    counted;
        int                    r;
        logic [KIND_W-1:0]     k;
        logic [ID_FIELD_W-1:0] id;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Basic allocation, reuse of a freed identifier, the odd frees, unused kinds and a clear.
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_ALLOC, 12'hFFF);
        send_req(KIND_ALLOC, 12'd5);
        send_req(KIND_FREE, 12'd2);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_FREE, 12'd2);
        send_req(KIND_FREE, 12'd2);
        send_req(KIND_FREE, 12'd0);
        send_req(KIND_FREE, 12'hFFF);
        send_req(KIND_UNUSED, 12'hFFF);
        send_req(KIND_UNUSED, 12'd0);
        send_req(KIND_CLEAR, 12'hABC);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_FREE, 12'd1);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_FREE, 12'd3);
        drain();

        // Fill the low words of the map so that searches cross many words,
        // then free and reuse around word boundaries.
        send_req(KIND_CLEAR, 12'd0);
        for (int n = 0; n < FILL_REQUESTS; n++)
        begin
            send_req(KIND_ALLOC, ID_FIELD_W'($urandom_range(0, ID_COUNT - 1)));
        end
        send_req(KIND_FREE, 12'd0);
        send_req(KIND_FREE, 12'd64);
        send_req(KIND_FREE, 12'd2048);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_FREE, 12'd1);
        send_req(KIND_FREE, 12'd63);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_ALLOC, 12'd0);
        send_req(KIND_FREE, 12'hFFF);
        send_req(KIND_CLEAR, 12'd0);
        send_req(KIND_ALLOC, 12'd0);
        drain();

        // Random mix, mostly allocations and frees of identifiers up to the highest granted.
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            r  = $urandom_range(0, 99);
            id = ID_FIELD_W'($urandom_range(0, ID_COUNT - 1));
            if (r < 45)
            begin
                k = KIND_ALLOC;
            end
            else if (r < 80)
            begin
                k  = KIND_FREE;
                id = ID_FIELD_W'($urandom_range(1, (sb.alloc_peak > 1) ? sb.alloc_peak : 1));
            end
            else if (r < 90)
            begin
                k = KIND_FREE;
            end
            else if (r < 93)
            begin
                k  = KIND_FREE;
                id = '0;
            end
            else if (r < 96)
            begin
                k = KIND_UNUSED;
            end
            else
            begin
                k = KIND_CLEAR;
            end
            send_req(k, id);
            counted++;
            if ($urandom_range(0, 99) == 0)
            begin
                drain();
            end
        end

        // Wait for the last results and a little longer for anything stray.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("bitmap_id_allocator: match");
        end
        else
        begin
            $display("bitmap_id_allocator: mismatch");
        end
        $finish;
    end

endmodule

FILE: bitmap_id_allocator.f
hw/rtl/bia_pkg.sv
hw/rtl/bia_ram.sv
hw/rtl/bia_out_buf.sv
hw/rtl/bitmap_id_allocator.sv
hw/rtl/bia_checker.sv
dv/bitmap_id_allocator_test.sv
